### sv/hcw_pkg.sv
package hcw_pkg;

    // production codes
    localparam logic [1:0] PROD_A = 2'd0;
    localparam logic [1:0] PROD_B = 2'd1;
    localparam logic [1:0] PROD_C = 2'd2;
    localparam logic [1:0] PROD_D = 2'd3;

    // move directions, screen y grows downward
    localparam logic [1:0] DIR_XP = 2'd0;
    localparam logic [1:0] DIR_YP = 2'd1;
    localparam logic [1:0] DIR_XM = 2'd2;
    localparam logic [1:0] DIR_YM = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_ORDER   = 2'd0;
    localparam logic [1:0] REG_STEP    = 2'd1;
    localparam logic [1:0] REG_START_X = 2'd2;
    localparam logic [1:0] REG_START_Y = 2'd3;

    localparam int ORDER_W = 4;
    localparam int STEP_W  = 9;
    localparam int START_W = 12;
    localparam int CFG_W   = 12;
    localparam int INDEX_W = 2;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } hcw_state_t;

    typedef struct packed {
        logic       found;
        logic [1:0] dir;
    } hcw_dec_t;

    // production of quarter j inside production p
    function automatic logic [1:0] sub_prod(input logic [1:0] p, input logic [1:0] j);
        logic [1:0] r;
        r = PROD_A;
        case (p)
            PROD_A:
                case (j)
                    2'd0:    r = PROD_D;
                    2'd3:    r = PROD_B;
                    default: r = PROD_A;
                endcase
            PROD_B:
                case (j)
                    2'd0:    r = PROD_C;
                    2'd3:    r = PROD_A;
                    default: r = PROD_B;
                endcase
            PROD_C:
                case (j)
                    2'd0:    r = PROD_B;
                    2'd3:    r = PROD_D;
                    default: r = PROD_C;
                endcase
            default:
                case (j)
                    2'd0:    r = PROD_A;
                    2'd3:    r = PROD_C;
                    default: r = PROD_D;
                endcase
        endcase
        return r;
    endfunction

    // connecting move after quarter j (j clamped to 2) of production p
    function automatic logic [1:0] prod_dir(input logic [1:0] p, input logic [1:0] j);
        logic [1:0] r;
        r = DIR_XP;
        case (p)
            PROD_A:
                case (j)
                    2'd0:    r = DIR_XM;
                    2'd1:    r = DIR_YM;
                    default: r = DIR_XP;
                endcase
            PROD_B:
                case (j)
                    2'd0:    r = DIR_YP;
                    2'd1:    r = DIR_XP;
                    default: r = DIR_YM;
                endcase
            PROD_C:
                case (j)
                    2'd0:    r = DIR_XP;
                    2'd1:    r = DIR_YP;
                    default: r = DIR_XM;
                endcase
            default:
                case (j)
                    2'd0:    r = DIR_YM;
                    2'd1:    r = DIR_XM;
                    default: r = DIR_YP;
                endcase
        endcase
        return r;
    endfunction

endpackage

### sv/hilbert_curve_walk_generator.sv
// Hilbert curve walk generator.
// Tick channel (tick_valid/tick_stall, field restart): each accepted item asks
// for the next unit move of the curve; restart=1 first returns the pen to the
// configured start and begins a fresh walk.
// Move channel (move_valid/move_stall): one item per tick with move_dir, pen_x,
// pen_y after the move (saturated at 0 and 2^COORD_BITS-1) and last_move on the
// final move of the curve; the walk then starts over on the next tick.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data): 0 curve_order,
// 1 step_len, 2 start_x, 3 start_y. cfg_ready is always high; write only idle.
// Timing: the move count is decoded one base-4 digit per cycle, top level
// first, through MAX_ORDER levels at most; the decode stops at the first level
// that yields the move, which then enters the output register; a new tick is
// taken the cycle after the move is registered.
// The result sits in an output register; tick_stall stays high only while a
// decode is in flight or its result cannot yet enter that register. A stalled
// move holds until taken.
// Reset: registers return to order 1, step 256, start (320, 240), and no walk
// is active, so the first tick begins a walk.
module hilbert_curve_walk_generator #(
    parameter int MAX_ORDER  = 8,
    parameter int COORD_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          tick_valid,
    output logic                          tick_stall,
    input  logic                          restart,
    output logic                          move_valid,
    input  logic                          move_stall,
    output logic [1:0]                    move_dir,
    output logic [COORD_BITS-1:0]         pen_x,
    output logic [COORD_BITS-1:0]         pen_y,
    output logic                          last_move,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hcw_pkg::INDEX_W-1:0]   cfg_index,
    input  logic [hcw_pkg::CFG_W-1:0]     cfg_data
);
    import hcw_pkg::*;

    localparam int CW = 2 * MAX_ORDER;
    localparam int LW = $clog2(MAX_ORDER + 1);
    localparam int AW = ((COORD_BITS > START_W) ? COORD_BITS : START_W) + 1;
    localparam logic [AW-1:0] COORD_MAX = AW'((1 << COORD_BITS) - 1);

    // configuration
    logic [ORDER_W-1:0] order_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [START_W-1:0] start_x_reg;
    logic [START_W-1:0] start_y_reg;

    // walk state
    hcw_state_t            state_reg;
    hcw_state_t            state_next;
    logic                  active_reg;
    logic                  active_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [COORD_BITS-1:0] pos_x_reg;
    logic [COORD_BITS-1:0] pos_x_next;
    logic [COORD_BITS-1:0] pos_y_reg;
    logic [COORD_BITS-1:0] pos_y_next;

    // output register
    logic                  move_valid_reg;
    logic                  move_valid_next;
    logic [1:0]            move_dir_reg;
    logic [COORD_BITS-1:0] pen_x_reg;
    logic [COORD_BITS-1:0] pen_y_reg;
    logic                  last_move_reg;

    logic                  tick_take;
    logic                  begin_walk;
    logic                  out_load;
    logic [4:0]            order_ext;
    logic [LW-1:0]         eff_order;
    logic [CW-1:0]         total;
    logic [CW-1:0]         load_count;
    logic [CW-1:0]         count_inc;
    logic [AW-1:0]         sx_ext;
    logic [AW-1:0]         sy_ext;
    logic [COORD_BITS-1:0] sat_start_x;
    logic [COORD_BITS-1:0] sat_start_y;
    logic [AW-1:0]         step_ext;
    logic [AW-1:0]         x_ext;
    logic [AW-1:0]         y_ext;
    logic [AW-1:0]         x_sum;
    logic [AW-1:0]         y_sum;
    logic [COORD_BITS-1:0] new_x;
    logic [COORD_BITS-1:0] new_y;
    logic                  is_last;
    hcw_dec_t              dec;

    assign cfg_ready = 1'b1;

    // clamp order to 1..MAX_ORDER
    assign order_ext = {1'b0, order_reg};
    always_comb
    begin
        if (order_ext == 5'd0)
        begin
            eff_order = LW'(1);
        end
        else if (order_ext > 5'(MAX_ORDER))
        begin
            eff_order = LW'(MAX_ORDER);
        end
        else
        begin
            eff_order = LW'(order_ext);
        end
    end

    // move total 4^n - 1: the low 2n bits set
    always_comb
    begin
        for (int b = 0; b < CW; b++)
        begin
            total[b] = (b < 2 * int'(eff_order));
        end
    end

    assign sx_ext      = AW'(start_x_reg);
    assign sy_ext      = AW'(start_y_reg);
    assign sat_start_x = (sx_ext > COORD_MAX) ? COORD_BITS'(COORD_MAX)
                                              : COORD_BITS'(sx_ext);
    assign sat_start_y = (sy_ext > COORD_MAX) ? COORD_BITS'(COORD_MAX)
                                              : COORD_BITS'(sy_ext);

    assign tick_take  = tick_valid && !tick_stall;
    assign begin_walk = restart || !active_reg || (count_reg >= total);
    assign load_count = begin_walk ? '0 : count_reg;

    hcw_decoder #(
        .MAX_ORDER (MAX_ORDER)
    ) u_decoder (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (tick_take),
        .count  (load_count),
        .order  (eff_order),
        .status (dec)
    );

    assign out_load = (state_reg == ST_WALK) && dec.found
                      && (!move_valid_reg || !move_stall);

    // pen step with saturation
    assign step_ext = AW'(step_reg);
    assign x_ext    = AW'(pos_x_reg);
    assign y_ext    = AW'(pos_y_reg);
    assign x_sum    = x_ext + step_ext;
    assign y_sum    = y_ext + step_ext;

    always_comb
    begin
        new_x = pos_x_reg;
        new_y = pos_y_reg;
        case (dec.dir)
            DIR_XP:  new_x = (x_sum > COORD_MAX) ? COORD_BITS'(COORD_MAX) : COORD_BITS'(x_sum);
            DIR_YP:  new_y = (y_sum > COORD_MAX) ? COORD_BITS'(COORD_MAX) : COORD_BITS'(y_sum);
            DIR_XM:  new_x = (x_ext > step_ext) ? COORD_BITS'(x_ext - step_ext) : '0;
            default: new_y = (y_ext > step_ext) ? COORD_BITS'(y_ext - step_ext) : '0;
        endcase
    end

    assign count_inc = count_reg + CW'(1);
    assign is_last   = (count_inc == total);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (tick_take)
                begin
                    state_next = ST_WALK;
                end
            ST_WALK:
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath updates
    always_comb
    begin
        tick_stall      = (state_reg != ST_IDLE);
        active_next     = active_reg;
        count_next      = count_reg;
        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        move_valid_next = move_valid_reg && move_stall;
        case (state_reg)
            ST_IDLE:
                if (tick_take && begin_walk)
                begin
                    active_next = 1'b1;
                    count_next  = '0;
                    pos_x_next  = sat_start_x;
                    pos_y_next  = sat_start_y;
                end
            ST_WALK:
                if (out_load)
                begin
                    count_next      = count_inc;
                    pos_x_next      = new_x;
                    pos_y_next      = new_y;
                    move_valid_next = 1'b1;
                    if (is_last)
                    begin
                        active_next = 1'b0;
                    end
                end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg      <= ORDER_W'(1);
            step_reg       <= STEP_W'(256);
            start_x_reg    <= START_W'(320);
            start_y_reg    <= START_W'(240);
            state_reg      <= ST_IDLE;
            active_reg     <= 1'b0;
            count_reg      <= '0;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            move_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ORDER:   order_reg   <= cfg_data[ORDER_W-1:0];
                    REG_STEP:    step_reg    <= cfg_data[STEP_W-1:0];
                    REG_START_X: start_x_reg <= cfg_data[START_W-1:0];
                    REG_START_Y: start_y_reg <= cfg_data[START_W-1:0];
                    default:     ;
                endcase
            end
            state_reg      <= state_next;
            active_reg     <= active_next;
            count_reg      <= count_next;
            pos_x_reg      <= pos_x_next;
            pos_y_reg      <= pos_y_next;
            move_valid_reg <= move_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            move_dir_reg  <= dec.dir;
            pen_x_reg     <= new_x;
            pen_y_reg     <= new_y;
            last_move_reg <= is_last;
        end
    end

    assign move_valid = move_valid_reg;
    assign move_dir   = move_dir_reg;
    assign pen_x      = pen_x_reg;
    assign pen_y      = pen_y_reg;
    assign last_move  = last_move_reg;

    // a taken tick always starts a decode
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_take |=> (state_reg == ST_WALK))
        else $error("tick taken without starting a decode");

    // a new move only comes out of a decode in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(move_valid_reg) |-> $past(state_reg == ST_WALK))
        else $error("move issued without a decode");

    // the final move closes the walk
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && is_last) |=> !active_reg)
        else $error("walk still active after its last move");

    // a held move is not overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (move_valid_reg && move_stall) |-> !out_load)
        else $error("output register loaded while stalled");

endmodule

### sv/hcw_decoder.sv
module hcw_decoder #(
    parameter int MAX_ORDER = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               load,
    input  logic [2*MAX_ORDER-1:0]             count,
    input  logic [$clog2(MAX_ORDER+1)-1:0]     order,
    output hcw_pkg::hcw_dec_t                  status
);
    import hcw_pkg::*;

    localparam int CW = 2 * MAX_ORDER;
    localparam int LW = $clog2(MAX_ORDER + 1);

    // move count, top digit first; the bottom fills with 3s as digits shift out
    logic [CW+1:0] sr_reg;
    logic [CW+1:0] sr_next;
    logic [LW-1:0] lvl_reg;
    logic [LW-1:0] lvl_next;
    logic [1:0]    prod_reg;
    logic [1:0]    prod_next;

    logic [1:0] digit;
    logic [1:0] digit_clamped;
    logic       rest_all3;
    logic       active_level;
    logic       found;

    assign digit         = sr_reg[CW+1:CW];
    assign digit_clamped = (digit == 2'd3) ? 2'd2 : digit;
    assign rest_all3     = &sr_reg[CW-1:0];
    assign active_level  = (lvl_reg != '0) && (lvl_reg <= order);
    assign found         = active_level && rest_all3;

    assign status.found = found;
    assign status.dir   = prod_dir(prod_reg, digit_clamped);

    always_comb
    begin
        sr_next   = sr_reg;
        lvl_next  = lvl_reg;
        prod_next = prod_reg;
        if (load)
        begin
            sr_next   = {count, 2'b11};
            lvl_next  = LW'(MAX_ORDER);
            prod_next = PROD_A;
        end
        else if (lvl_reg != '0 && !found)
        begin
            // levels above the order carry zero digits: skip them
            sr_next  = {sr_reg[CW-1:0], 2'b11};
            lvl_next = lvl_reg - LW'(1);
            if (active_level)
            begin
                prod_next = sub_prod(prod_reg, digit);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sr_reg   <= '1;
            lvl_reg  <= '0;
            prod_reg <= PROD_A;
        end
        else
        begin
            sr_reg   <= sr_next;
            lvl_reg  <= lvl_next;
            prod_reg <= prod_next;
        end
    end

endmodule

### bench/hcw_move_checker.sv
module hcw_move_checker #(
    parameter int MAX_ORDER  = 8,
    parameter int COORD_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          tick_valid,
    input  logic                          tick_stall,
    input  logic                          restart,
    input  logic                          move_valid,
    input  logic                          move_stall,
    input  logic [1:0]                    move_dir,
    input  logic [COORD_BITS-1:0]         pen_x,
    input  logic [COORD_BITS-1:0]         pen_y,
    input  logic                          last_move,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [hcw_pkg::INDEX_W-1:0]   cfg_index,
    input  logic [hcw_pkg::CFG_W-1:0]     cfg_data,
    output int                            errors,
    output int                            pending,
    output int                            checked,
    output int                            curves
);
    timeunit 1ns;
    timeprecision 1ps;

    import hcw_pkg::*;

    localparam int COORD_MAX = (1 << COORD_BITS) - 1;

    // child production of quarter j inside production p, entry p*4+j
    localparam logic [31:0] CHILD_PROD = {
        PROD_C, PROD_D, PROD_D, PROD_A,
        PROD_D, PROD_C, PROD_C, PROD_B,
        PROD_A, PROD_B, PROD_B, PROD_C,
        PROD_B, PROD_A, PROD_A, PROD_D
    };
    // joining move after quarter j of production p; quarter 3 repeats quarter 2
    localparam logic [31:0] JOIN_DIR = {
        DIR_YP, DIR_YP, DIR_XM, DIR_YM,
        DIR_XM, DIR_XM, DIR_YP, DIR_XP,
        DIR_YM, DIR_YM, DIR_XP, DIR_YP,
        DIR_XP, DIR_XP, DIR_YM, DIR_XM
    };

    typedef struct packed {
        logic [1:0]            dir;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  is_last;
    } move_t;

    move_t expected_moves[$];
    move_t want;

    logic [ORDER_W-1:0] cfg_order  = 4'd1;
    logic [STEP_W-1:0]  cfg_step   = 9'd256;
    logic [START_W-1:0] cfg_start_x = 12'd320;
    logic [START_W-1:0] cfg_start_y = 12'd240;

    int unsigned walk_x     = 0;
    int unsigned walk_y     = 0;
    int unsigned walk_count = 0;
    bit          walk_on    = 0;

    task automatic predict_next_move(input logic restart_req);
        int unsigned n;
        int unsigned total;
        int unsigned r;
        int unsigned blk;
        int unsigned rest;
        int          lvl;
        int          idx;
        bit          found;
        logic [1:0]  prod;
        logic [1:0]  quarter;
        logic [1:0]  dir;
        move_t       m;

        n = 32'(cfg_order);
        if (n < 1) n = 1;
        if (n > MAX_ORDER) n = MAX_ORDER;
        total = (1 << (2 * n)) - 1;

        if (restart_req || !walk_on || walk_count >= total)
        begin
            walk_x     = 32'(cfg_start_x);
            walk_y     = 32'(cfg_start_y);
            walk_count = 0;
            walk_on    = 1;
        end

        // descend the production path given by the base-4 digits of the count
        prod  = PROD_A;
        dir   = DIR_XP;
        r     = walk_count;
        found = 0;
        for (lvl = n; lvl >= 1 && !found; lvl--)
        begin
            blk     = 1 << (2 * (lvl - 1));
            quarter = 2'((r / blk) % 4);
            rest    = r % blk;
            idx     = int'(prod) * 4 + int'(quarter);
            if (rest == blk - 1)
            begin
                dir   = JOIN_DIR[idx*2 +: 2];
                found = 1;
            end
            else
            begin
                prod = CHILD_PROD[idx*2 +: 2];
                r    = rest;
            end
        end

        case (dir)
            DIR_XP: walk_x = (walk_x + cfg_step > COORD_MAX) ? COORD_MAX : walk_x + cfg_step;
            DIR_YP: walk_y = (walk_y + cfg_step > COORD_MAX) ? COORD_MAX : walk_y + cfg_step;
            DIR_XM: walk_x = (walk_x > cfg_step) ? walk_x - cfg_step : 0;
            default: walk_y = (walk_y > cfg_step) ? walk_y - cfg_step : 0;
        endcase

        walk_count++;
        m.dir     = dir;
        m.x       = walk_x[COORD_BITS-1:0];
        m.y       = walk_y[COORD_BITS-1:0];
        m.is_last = (walk_count >= total);
        if (m.is_last) walk_on = 0;
        expected_moves.push_back(m);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_order   = 4'd1;
            cfg_step    = 9'd256;
            cfg_start_x = 12'd320;
            cfg_start_y = 12'd240;
            walk_x      = 0;
            walk_y      = 0;
            walk_count  = 0;
            walk_on     = 0;
            expected_moves.delete();
            pending     = 0;
            errors      = 0;
            checked     = 0;
            curves      = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ORDER:   cfg_order   = cfg_data[ORDER_W-1:0];
                    REG_STEP:    cfg_step    = cfg_data[STEP_W-1:0];
                    REG_START_X: cfg_start_x = cfg_data[START_W-1:0];
                    default:     cfg_start_y = cfg_data[START_W-1:0];
                endcase
            end

            if (move_valid && !move_stall)
            begin
                if (expected_moves.size() == 0)
                begin
                    $display("%0t: unexpected move dir=%0d x=%0d y=%0d last=%0b",
                             $time, move_dir, pen_x, pen_y, last_move);
                    errors++;
                end
                else
                begin
                    want = expected_moves.pop_front();
                    checked++;
                    if (want.is_last) curves++;
                    if (move_dir !== want.dir)
                    begin
                        $display("%0t: move_dir expected %0d got %0d", $time, want.dir, move_dir);
                        errors++;
                    end
                    if (pen_x !== want.x)
                    begin
                        $display("%0t: pen_x expected %0d got %0d", $time, want.x, pen_x);
                        errors++;
                    end
                    if (pen_y !== want.y)
                    begin
                        $display("%0t: pen_y expected %0d got %0d", $time, want.y, pen_y);
                        errors++;
                    end
                    if (last_move !== want.is_last)
                    begin
                        $display("%0t: last_move expected %0b got %0b",
                                 $time, want.is_last, last_move);
                        errors++;
                    end
                end
            end

            if (tick_valid && !tick_stall)
                predict_next_move(restart);

            pending = expected_moves.size();
        end
    end

endmodule

### bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hcw_pkg::*;

    localparam int MAX_ORDER  = 8;
    localparam int COORD_BITS = 12;
    localparam int RANDOM_TICKS = 850;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  tick_valid = 1'b0;
    logic                  tick_stall;
    logic                  restart    = 1'b0;
    logic                  move_valid;
    logic                  move_stall = 1'b0;
    logic [1:0]            move_dir;
    logic [COORD_BITS-1:0] pen_x;
    logic [COORD_BITS-1:0] pen_y;
    logic                  last_move;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    logic [INDEX_W-1:0]    cfg_index  = '0;
    logic [CFG_W-1:0]      cfg_data   = '0;

    int errors;
    int pending;
    int checked;
    int curves;

    int ticks_sent  = 0;
    int settings    = 0;
    int burst_left  = 0;
    int stall_left  = 0;
    int stall_mode  = 0;

    always #5 clk = ~clk;

    hilbert_curve_walk_generator #(
        .MAX_ORDER  (MAX_ORDER),
        .COORD_BITS (COORD_BITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_stall (tick_stall),
        .restart    (restart),
        .move_valid (move_valid),
        .move_stall (move_stall),
        .move_dir   (move_dir),
        .pen_x      (pen_x),
        .pen_y      (pen_y),
        .last_move  (last_move),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    hcw_move_checker #(
        .MAX_ORDER  (MAX_ORDER),
        .COORD_BITS (COORD_BITS)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_stall (tick_stall),
        .restart    (restart),
        .move_valid (move_valid),
        .move_stall (move_stall),
        .move_dir   (move_dir),
        .pen_x      (pen_x),
        .pen_y      (pen_y),
        .last_move  (last_move),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .errors     (errors),
        .pending    (pending),
        .checked    (checked),
        .curves     (curves)
    );

    // receiver: switch between free flow, light, even and heavy back-pressure
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 60);
        end
        stall_left--;
        case (stall_mode)
            0: move_stall <= 1'b0;
            1: move_stall <= ($urandom_range(0, 3) == 0);
            2: move_stall <= 1'($urandom_range(0, 1));
            default: move_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_tick(input logic restart_req);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            tick_valid <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 12);
        end
        tick_valid <= 1'b1;
        restart    <= restart_req;
        @(posedge clk);
        while (tick_stall) @(posedge clk);
        burst_left--;
        ticks_sent++;
    endtask

    // drop the stream and let every move drain before touching registers
    task automatic drain;
        @(negedge clk);
        tick_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge clk);
        repeat (MAX_ORDER + 2) @(negedge clk);
    endtask

    task automatic load_setting(input logic [ORDER_W-1:0] order, input logic [STEP_W-1:0] step,
                                input logic [START_W-1:0] sx, input logic [START_W-1:0] sy);
        drain();
        write_reg(REG_ORDER,   {8'($urandom_range(0, 255)), order});
        write_reg(REG_STEP,    {3'($urandom_range(0, 7)), step});
        write_reg(REG_START_X, sx);
        write_reg(REG_START_Y, sy);
        settings++;
    endtask

    initial
    begin
        logic [ORDER_W-1:0] order;
        logic [STEP_W-1:0]  step;
        logic [START_W-1:0] sx;
        logic [START_W-1:0] sy;
        int                 pick;
        int                 count;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset values: one full order-1 walk, then wrap to a new one
        repeat (3) send_tick(1'b0);
        send_tick(1'b1);

        // order zero acts as one; start on the right edge, saturate at the top edge
        load_setting(4'd0, 9'd511, 12'd4095, 12'd0);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);

        // order above range acts as the maximum; zero step holds the pen
        load_setting(4'd15, 9'd0, 12'd0, 12'd4095);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);

        // deep walk from the origin: every direction, clipping at zero
        load_setting(4'd3, 9'd511, 12'd0, 12'd0);
        repeat (10) send_tick(1'b0);

        // shrink the order below the moves already made: fresh walk
        load_setting(4'd1, 9'd7, 12'd4000, 12'd4000);
        send_tick(1'b0);
        send_tick(1'b0);

        count = 0;
        while (count < RANDOM_TICKS)
        begin
            pick  = $urandom_range(0, 19);
            order = (pick == 0) ? 4'd0 :
                    (pick == 1) ? 4'($urandom_range(9, 15)) :
                    (pick < 5)  ? 4'($urandom_range(5, 8)) :
                                  4'($urandom_range(1, 4));
            pick  = $urandom_range(0, 9);
            step  = (pick == 0) ? 9'd0 : (pick == 1) ? 9'd511 : (pick == 2) ? 9'd1 :
                    9'($urandom_range(0, 511));
            pick  = $urandom_range(0, 5);
            sx    = (pick == 0) ? 12'd0 : (pick == 1) ? 12'd4095 : 12'($urandom);
            pick  = $urandom_range(0, 5);
            sy    = (pick == 0) ? 12'd0 : (pick == 1) ? 12'd4095 : 12'($urandom);
            load_setting(order, step, sx, sy);
            repeat ($urandom_range(10, 90))
            begin
                send_tick($urandom_range(0, 15) == 0);
                count++;
            end
        end

        drain();
        repeat (4 * MAX_ORDER) @(negedge clk);

        $display("tb: %0d ticks sent across %0d register settings", ticks_sent, settings);
        $display("tb: %0d moves compared, %0d complete curves seen", checked, curves);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
